/* sv/rrs_pkg.sv */
// Shared constants and controller/datapath interface types for the round-robin scheduler.
// No dependencies; the top level, controller and datapath import this package.
package rrs_pkg;

  localparam int MAX_PROCS = 32;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int TIME_W    = 22;
  localparam int ARR_W     = 16;
  localparam int ID_W      = 8;
  localparam logic [15:0] QUANTUM_RST = 16'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // store accepted job
    logic init;      // start clock at first job, queue it
    logic idx_clr;
    logic idx_inc;
    logic min_clr;   // start search for earliest unadmitted arrival
    logic min_chk;
    logic jump;      // advance clock to earliest arrival
    logic pop;       // take queue head as current job
    logic exec;      // run current job for one slice
    logic adm_chk;   // admit scanned job if arrived
    logic push_cur;  // requeue preempted job
    logic out_ld;    // load result register
    logic clear;     // empty the table for the next batch
  } rrs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic idx_end;
    logic fifo_empty;
    logic all_done;
    logic out_fire;
    logic out_last;
  } rrs_stat_t;

endpackage

/* sv/round_robin_schedule_sim.sv */
// Round-robin scheduler top level: jobs load one per cycle while in_ready is high.
// After the last job the clock is set up; each dispatch pops the queue head, runs
// one slice and scans the stored jobs for admission; an idle-time search first
// finds the earliest unadmitted arrival. Results then leave one at a time, each
// after the previous is taken; in_ready returns after the last. Synchronous reset
// empties the table and sets the quantum to 4. Depends on rrs_pkg, rrs_ctrl, rrs_dp.
module round_robin_schedule_sim
  import rrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ID_W-1:0]   job_id,
  input  logic [ARR_W-1:0]  arrival_time,
  input  logic [ARR_W-1:0]  burst_time,
  input  logic              last_job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   out_job_id,
  output logic [TIME_W-1:0] completion_time,
  output logic [TIME_W-1:0] turnaround_time,
  output logic [TIME_W-1:0] waiting_time,
  output logic              last_result
);

  rrs_cmd_t  cmd;
  rrs_stat_t stat;

  rrs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .last_job, .in_ready, .stat, .cmd
  );

  rrs_dp u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_wdata,
    .job_id, .arrival_time, .burst_time,
    .out_valid, .out_ready, .out_job_id, .completion_time,
    .turnaround_time, .waiting_time, .last_result
  );

endmodule

/* sv/rrs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrs_ram #(
  parameter int W = 8,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/rrs_ctrl.sv */
// Controller state machine: load, simulate, report.
// Depends on rrs_pkg.
module rrs_ctrl
  import rrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      last_job,
  output logic      in_ready,
  input  rrs_stat_t stat,
  output rrs_cmd_t  cmd
);

  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_INIT_RD = 4'd1;
  localparam logic [3:0] S_INIT    = 4'd2;
  localparam logic [3:0] S_DISP    = 4'd3;
  localparam logic [3:0] S_POP     = 4'd4;
  localparam logic [3:0] S_REM_RD  = 4'd5;
  localparam logic [3:0] S_EXEC    = 4'd6;
  localparam logic [3:0] S_ADM_RD  = 4'd7;
  localparam logic [3:0] S_ADM_CHK = 4'd8;
  localparam logic [3:0] S_MIN_RD  = 4'd9;
  localparam logic [3:0] S_MIN_CHK = 4'd10;
  localparam logic [3:0] S_OUT_RD  = 4'd11;
  localparam logic [3:0] S_OUT_LD  = 4'd12;
  localparam logic [3:0] S_OUT_WT  = 4'd13;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_LOAD);

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last_job) begin
            cmd.idx_clr = 1'b1;
            state_next = S_INIT_RD;
          end
        end
      end
      S_INIT_RD: state_next = S_INIT;
      S_INIT: begin
        cmd.init = 1'b1;
        state_next = S_DISP;
      end
      S_DISP: begin
        cmd.idx_clr = 1'b1;
        if (stat.all_done) begin
          state_next = S_OUT_RD;
        end else if (stat.fifo_empty) begin
          cmd.min_clr = 1'b1;
          state_next = S_MIN_RD;
        end else begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        state_next = S_REM_RD;
      end
      S_REM_RD: state_next = S_EXEC;
      S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.idx_clr = 1'b1;
        state_next = S_ADM_RD;
      end
      S_ADM_RD: begin
        if (stat.idx_end) begin
          cmd.push_cur = 1'b1;
          state_next = S_DISP;
        end else begin
          state_next = S_ADM_CHK;
        end
      end
      S_ADM_CHK: begin
        cmd.adm_chk = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next = S_ADM_RD;
      end
      S_MIN_RD: begin
        if (stat.idx_end) begin
          cmd.jump = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next = S_ADM_RD;
        end else begin
          state_next = S_MIN_CHK;
        end
      end
      S_MIN_CHK: begin
        cmd.min_chk = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next = S_MIN_RD;
      end
      S_OUT_RD: state_next = S_OUT_LD;
      S_OUT_LD: begin
        cmd.out_ld = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next = S_OUT_WT;
      end
      S_OUT_WT: begin
        if (stat.out_fire) begin
          if (stat.out_last) begin
            cmd.clear = 1'b1;
            state_next = S_LOAD;
          end else begin
            state_next = S_OUT_RD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

/* sv/rrs_dp.sv */
// Datapath: job tables, ready queue, clock, counters and result register.
// Depends on rrs_pkg and rrs_ram.
module rrs_dp
  import rrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  rrs_cmd_t          cmd,
  output rrs_stat_t         stat,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic [ID_W-1:0]   job_id,
  input  logic [ARR_W-1:0]  arrival_time,
  input  logic [ARR_W-1:0]  burst_time,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   out_job_id,
  output logic [TIME_W-1:0] completion_time,
  output logic [TIME_W-1:0] turnaround_time,
  output logic [TIME_W-1:0] waiting_time,
  output logic              last_result
);

  logic [15:0]          quantum;
  logic [CNT_W-1:0]     jobs_loaded;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     done;
  logic [CNT_W-1:0]     fifo_count;
  logic [IDX_W-1:0]     fifo_head, fifo_tail;
  logic [IDX_W-1:0]     cur_j;
  logic                 requeue;
  logic [TIME_W-1:0]    sim_time;
  logic [ARR_W:0]       best;
  logic [MAX_PROCS-1:0] admitted;

  logic [ARR_W-1:0]  arr_rd, burst_rd, rem_rd;
  logic [ID_W-1:0]   id_rd;
  logic [TIME_W-1:0] fin_rd;
  logic [IDX_W-1:0]  fifo_rd;

  logic [IDX_W-1:0]  idx_a;
  logic              full, ld_we;
  logic [15:0]       q_eff;
  logic              rem_le;
  logic              adm_push, fifo_we;
  logic [IDX_W-1:0]  fifo_wdata;
  logic              rem_we;
  logic [IDX_W-1:0]  rem_waddr;
  logic [ARR_W-1:0]  rem_wdata;
  logic [TIME_W-1:0] fin_time;
  logic [TIME_W-1:0] tat;

  assign idx_a    = idx[IDX_W-1:0];
  assign full     = (jobs_loaded == CNT_W'(MAX_PROCS));
  assign ld_we    = cmd.load & ~full;
  assign q_eff    = (quantum == 16'd0) ? 16'd1 : quantum;
  assign rem_le   = (rem_rd <= q_eff);
  assign fin_time = sim_time + TIME_W'(rem_rd);
  assign adm_push = cmd.adm_chk & ~admitted[idx_a]
                    & (TIME_W'(arr_rd) <= sim_time);
  assign fifo_we  = cmd.init | adm_push | (cmd.push_cur & requeue);

  // Queue write data: first job, newly arrived job, or preempted job
  always_comb begin
    if (cmd.init) begin
      fifo_wdata = '0;
    end else if (adm_push) begin
      fifo_wdata = idx_a;
    end else begin
      fifo_wdata = cur_j;
    end
  end

  // Remaining time: written on load and on preemption
  assign rem_we    = ld_we | (cmd.exec & ~rem_le);
  assign rem_waddr = ld_we ? jobs_loaded[IDX_W-1:0] : cur_j;
  assign rem_wdata = ld_we ? burst_time : (rem_rd - q_eff);

  rrs_ram #(.W(ARR_W), .D(MAX_PROCS)) u_arr (
    .clk, .we(ld_we), .waddr(jobs_loaded[IDX_W-1:0]), .wdata(arrival_time),
    .raddr(idx_a), .rdata(arr_rd));
  rrs_ram #(.W(ARR_W), .D(MAX_PROCS)) u_burst (
    .clk, .we(ld_we), .waddr(jobs_loaded[IDX_W-1:0]), .wdata(burst_time),
    .raddr(idx_a), .rdata(burst_rd));
  rrs_ram #(.W(ID_W), .D(MAX_PROCS)) u_id (
    .clk, .we(ld_we), .waddr(jobs_loaded[IDX_W-1:0]), .wdata(job_id),
    .raddr(idx_a), .rdata(id_rd));
  rrs_ram #(.W(ARR_W), .D(MAX_PROCS)) u_rem (
    .clk, .we(rem_we), .waddr(rem_waddr), .wdata(rem_wdata),
    .raddr(cur_j), .rdata(rem_rd));
  rrs_ram #(.W(TIME_W), .D(MAX_PROCS)) u_fin (
    .clk, .we(cmd.exec & rem_le), .waddr(cur_j), .wdata(fin_time),
    .raddr(idx_a), .rdata(fin_rd));
  rrs_ram #(.W(IDX_W), .D(MAX_PROCS)) u_fifo (
    .clk, .we(fifo_we), .waddr(fifo_tail), .wdata(fifo_wdata),
    .raddr(fifo_head), .rdata(fifo_rd));

  // Quantum register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RST;
    end else if (cfg_we) begin
      quantum <= cfg_wdata;
    end
  end

  // Table fill, scan index, completion count, admitted flags
  always_ff @(posedge clk) begin
    if (rst) begin
      jobs_loaded <= '0;
      idx         <= '0;
      done        <= '0;
      admitted    <= '0;
    end else begin
      if (ld_we) begin
        jobs_loaded <= jobs_loaded + 1'b1;
      end else if (cmd.clear) begin
        jobs_loaded <= '0;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.init) begin
        done <= '0;
      end else if (cmd.exec & rem_le) begin
        done <= done + 1'b1;
      end
      if (cmd.clear) begin
        admitted <= '0;
      end else if (cmd.init) begin
        admitted[0] <= 1'b1;
      end else if (adm_push) begin
        admitted[idx_a] <= 1'b1;
      end
    end
  end

  // Ready queue pointers; emptied between batches so the first job lands in slot 0
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head  <= '0;
      fifo_tail  <= '0;
      fifo_count <= '0;
    end else if (cmd.clear) begin
      fifo_head  <= '0;
      fifo_tail  <= '0;
      fifo_count <= '0;
    end else if (cmd.init) begin
      fifo_head  <= '0;
      fifo_tail  <= IDX_W'(1);
      fifo_count <= CNT_W'(1);
    end else if (cmd.pop) begin
      fifo_head  <= fifo_head + 1'b1;
      fifo_count <= fifo_count - 1'b1;
    end else if (fifo_we) begin
      fifo_tail  <= fifo_tail + 1'b1;
      fifo_count <= fifo_count + 1'b1;
    end
  end

  // Clock and requeue flag; current job and earliest-arrival search below
  always_ff @(posedge clk) begin
    if (rst) begin
      sim_time <= '0;
      requeue  <= 1'b0;
    end else begin
      if (cmd.init) begin
        sim_time <= TIME_W'(arr_rd);
      end else if (cmd.exec) begin
        sim_time <= rem_le ? fin_time : (sim_time + TIME_W'(q_eff));
      end else if (cmd.jump && (TIME_W'(best) > sim_time)) begin
        sim_time <= TIME_W'(best);
      end
      if (cmd.exec) begin
        requeue <= ~rem_le;
      end else if (cmd.min_clr) begin
        requeue <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      cur_j <= fifo_rd;
    end
    if (cmd.min_clr) begin
      best <= '1;
    end else if (cmd.min_chk && !admitted[idx_a] && ({1'b0, arr_rd} < best)) begin
      best <= {1'b0, arr_rd};
    end
  end

  // Result register
  assign tat = fin_rd - TIME_W'(arr_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_job_id      <= id_rd;
      completion_time <= fin_rd;
      turnaround_time <= tat;
      waiting_time    <= tat - TIME_W'(burst_rd);
      last_result     <= ((idx + 1'b1) == jobs_loaded);
    end
  end

  assign stat.idx_end    = (idx == jobs_loaded);
  assign stat.fifo_empty = (fifo_count == '0);
  assign stat.all_done   = (done == jobs_loaded);
  assign stat.out_fire   = out_valid & out_ready;
  assign stat.out_last   = last_result;

endmodule
